/* hdl/slp_pkg.sv */
// Shared types, codes and a helper function for the S-record line parser.
package slp_pkg;

    typedef enum logic [2:0] {
        PH_LINE,
        PH_TYPE,
        PH_COUNT,
        PH_ADDR_HI,
        PH_ADDR_LO,
        PH_DATA,
        PH_CKSUM,
        PH_TAIL
    } phase_t;

    typedef enum logic [1:0] {
        REC_S0,
        REC_S1,
        REC_S5,
        REC_S9
    } rec_t;

    localparam logic [2:0] KIND_WRITE = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_WARN  = 3'd2;
    localparam logic [2:0] KIND_ERROR = 3'd3;
    localparam logic [2:0] KIND_END   = 3'd4;

    localparam logic [1:0] ERR_SHORT = 2'd0;
    localparam logic [1:0] ERR_NO_S  = 2'd1;
    localparam logic [1:0] ERR_TYPE  = 2'd2;
    localparam logic [1:0] ERR_COUNT = 2'd3;

    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_S   = 8'h53;
    localparam logic [7:0] CH_DOT = 8'h2e;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_1   = 8'h31;
    localparam logic [7:0] CH_5   = 8'h35;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_LC_A = 8'h61;
    localparam logic [7:0] CH_LC_Z = 8'h7a;

    localparam logic [7:0] HDR_BYTES = 8'd3;

    // Hex digit value; other codes keep the low nibble of the letter mapping.
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= CH_0 && c <= CH_9) begin
            u = c - CH_0;
        end
        else begin
            if (c >= CH_LC_A && c <= CH_LC_Z) begin
                u = c - 8'd32;
            end
            u = u + 8'd9;
        end
        return u[3:0];
    endfunction

endpackage

/* hdl/srecord_loader_parser.sv */
// S-record line parser: one character per request, at most one result per character.
// A result's character passes through the input register and the parse stage into the result register.
// Throughput: one character per cycle while out_stall is low; an input register and
// a result register surround the single parse stage, and a waiting result holds it.
// Reset (rst_n low, asynchronous) empties both registers and puts the parser at
// line start with zero record count; restart does only the latter, before its character.
module srecord_loader_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_in,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [15:0] address,
    output logic [7:0]  data,
    output logic [1:0]  error_code,
    output logic [15:0] record_count
);
    import slp_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       restart_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    rec_t        rec_reg, rec_next;
    logic [3:0]  high_reg, high_next;
    logic        odd_reg, odd_next;
    logic [7:0]  left_reg, left_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] records_reg, records_next;
    logic        stopped_reg, stopped_next;

    // result register
    logic        out_valid_reg;
    logic [2:0]  kind_reg, kind_next;
    logic [15:0] address_reg, address_next;
    logic [7:0]  data_reg, data_next;
    logic [1:0]  code_reg, code_next;
    logic [15:0] count_reg;
    logic        has_result;

    logic can_advance, proc;

    // state as seen by this character (restart applies first)
    phase_t      eff_phase;
    rec_t        eff_rec;
    logic [3:0]  eff_high;
    logic        eff_odd;
    logic [7:0]  eff_left;
    logic [15:0] eff_addr;
    logic [7:0]  eff_sum;
    logic [15:0] eff_records;
    logic        eff_stopped;

    logic        eol;
    logic [3:0]  nib;
    logic [7:0]  byte_val;
    logic [15:0] addr_lo;
    logic [7:0]  left_dec;
    logic        type_ok;

    assign can_advance = !out_valid_reg || !out_stall;
    assign proc        = in_valid_reg && can_advance;
    assign in_stall    = in_valid_reg && !can_advance;

    always_comb
    begin
        if (restart_reg) begin
            eff_phase   = PH_LINE;
            eff_rec     = REC_S0;
            eff_high    = 4'd0;
            eff_odd     = 1'b0;
            eff_left    = 8'd0;
            eff_addr    = 16'd0;
            eff_sum     = 8'd0;
            eff_records = 16'd0;
            eff_stopped = 1'b0;
        end
        else begin
            eff_phase   = phase_reg;
            eff_rec     = rec_reg;
            eff_high    = high_reg;
            eff_odd     = odd_reg;
            eff_left    = left_reg;
            eff_addr    = addr_reg;
            eff_sum     = sum_reg;
            eff_records = records_reg;
            eff_stopped = stopped_reg;
        end
    end

    assign eol      = (char_reg == CH_LF) || (char_reg == CH_CR);
    assign nib      = nibble_of(char_reg);
    assign byte_val = {eff_high, nib};
    assign addr_lo  = eff_addr | {8'd0, byte_val};
    assign left_dec = eff_left - 8'd1;
    assign type_ok  = (char_reg == CH_0) || (char_reg == CH_1)
                   || (char_reg == CH_5) || (char_reg == CH_9);

    // next phase
    always_comb
    begin
        phase_next = eff_phase;
        if (!eff_stopped) begin
            case (eff_phase)
                PH_LINE:
                begin
                    if (char_reg == CH_S) begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_TAIL:
                begin
                    if (eol) begin
                        phase_next = PH_LINE;
                    end
                end
                PH_TYPE:
                begin
                    if (!eol && type_ok) begin
                        phase_next = PH_COUNT;
                    end
                end
                PH_COUNT:
                begin
                    if (!eol && eff_odd) begin
                        phase_next = PH_ADDR_HI;
                    end
                end
                PH_ADDR_HI:
                begin
                    if (!eol && eff_odd) begin
                        phase_next = PH_ADDR_LO;
                    end
                end
                PH_ADDR_LO:
                begin
                    if (!eol && eff_odd) begin
                        if (eff_rec == REC_S5) begin
                            phase_next = PH_TAIL;
                        end
                        else if (eff_rec == REC_S9 || eff_left == 8'd0) begin
                            phase_next = PH_CKSUM;
                        end
                        else begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    if (!eol && eff_odd && left_dec == 8'd0) begin
                        phase_next = PH_CKSUM;
                    end
                end
                PH_CKSUM:
                begin
                    if (!eol && eff_odd) begin
                        phase_next = PH_TAIL;
                    end
                end
                default:
                begin
                    phase_next = PH_TAIL;
                end
            endcase
        end
    end

    // datapath state and result
    always_comb
    begin
        rec_next     = eff_rec;
        high_next    = eff_high;
        odd_next     = eff_odd;
        left_next    = eff_left;
        addr_next    = eff_addr;
        sum_next     = eff_sum;
        records_next = eff_records;
        stopped_next = eff_stopped;
        has_result   = 1'b0;
        kind_next    = KIND_WRITE;
        address_next = 16'd0;
        data_next    = 8'd0;
        code_next    = ERR_SHORT;
        if (!eff_stopped) begin
            case (eff_phase)
                PH_LINE:
                begin
                    if (!eol) begin
                        if (char_reg == CH_DOT) begin
                            stopped_next = 1'b1;
                            has_result   = 1'b1;
                            kind_next    = KIND_END;
                        end
                        else if (char_reg != CH_S) begin
                            stopped_next = 1'b1;
                            has_result   = 1'b1;
                            kind_next    = KIND_ERROR;
                            code_next    = ERR_NO_S;
                        end
                    end
                end
                PH_TAIL:
                begin
                end
                default:
                begin
                    if (eol) begin
                        stopped_next = 1'b1;
                        has_result   = 1'b1;
                        kind_next    = KIND_ERROR;
                        code_next    = ERR_SHORT;
                    end
                    else if (eff_phase == PH_TYPE) begin
                        odd_next = 1'b0;
                        case (char_reg)
                            CH_0: rec_next = REC_S0;
                            CH_1:
                            begin
                                rec_next     = REC_S1;
                                records_next = eff_records + 16'd1;
                            end
                            CH_5: rec_next = REC_S5;
                            CH_9: rec_next = REC_S9;
                            default:
                            begin
                                odd_next     = eff_odd;
                                stopped_next = 1'b1;
                                has_result   = 1'b1;
                                kind_next    = KIND_ERROR;
                                code_next    = ERR_TYPE;
                            end
                        endcase
                    end
                    else if (!eff_odd) begin
                        high_next = nib;
                        odd_next  = 1'b1;
                    end
                    else begin
                        odd_next = 1'b0;
                        case (eff_phase)
                            PH_COUNT:
                            begin
                                sum_next  = byte_val;
                                left_next = (byte_val >= HDR_BYTES) ?
                                            byte_val - HDR_BYTES : 8'd0;
                            end
                            PH_ADDR_HI:
                            begin
                                sum_next  = eff_sum + byte_val;
                                addr_next = {byte_val, 8'd0};
                            end
                            PH_ADDR_LO:
                            begin
                                sum_next  = eff_sum + byte_val;
                                addr_next = addr_lo;
                                if (eff_rec == REC_S5) begin
                                    if (addr_lo != eff_records) begin
                                        stopped_next = 1'b1;
                                        has_result   = 1'b1;
                                        kind_next    = KIND_ERROR;
                                        code_next    = ERR_COUNT;
                                    end
                                    else begin
                                        records_next = 16'd0;
                                    end
                                end
                                else if (eff_rec == REC_S9) begin
                                    has_result   = 1'b1;
                                    kind_next    = KIND_START;
                                    address_next = addr_lo;
                                end
                            end
                            PH_DATA:
                            begin
                                sum_next  = eff_sum + byte_val;
                                left_next = left_dec;
                                if (eff_rec == REC_S1) begin
                                    addr_next    = eff_addr + 16'd1;
                                    has_result   = 1'b1;
                                    kind_next    = KIND_WRITE;
                                    address_next = eff_addr;
                                    data_next    = byte_val;
                                end
                            end
                            PH_CKSUM:
                            begin
                                if (~eff_sum != byte_val) begin
                                    has_result = 1'b1;
                                    kind_next  = KIND_WARN;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_LINE;
            rec_reg       <= REC_S0;
            high_reg      <= 4'd0;
            odd_reg       <= 1'b0;
            left_reg      <= 8'd0;
            addr_reg      <= 16'd0;
            sum_reg       <= 8'd0;
            records_reg   <= 16'd0;
            stopped_reg   <= 1'b0;
        end
        else begin
            if (!in_stall) begin
                in_valid_reg <= in_valid;
            end
            if (can_advance) begin
                out_valid_reg <= proc && has_result;
            end
            if (proc) begin
                phase_reg   <= phase_next;
                rec_reg     <= rec_next;
                high_reg    <= high_next;
                odd_reg     <= odd_next;
                left_reg    <= left_next;
                addr_reg    <= addr_next;
                sum_reg     <= sum_next;
                records_reg <= records_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            char_reg    <= char_in;
            restart_reg <= restart;
        end
        if (proc) begin
            kind_reg    <= kind_next;
            address_reg <= address_next;
            data_reg    <= data_next;
            code_reg    <= code_next;
            count_reg   <= records_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign address      = address_reg;
    assign data         = data_reg;
    assign error_code   = code_reg;
    assign record_count = count_reg;

    // a stopped parser stays silent until restart
    a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
        proc && stopped_reg && !restart_reg |=> !out_valid)
        else $error("result produced while stopped");

    // error and end results always stop the parser
    a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
        proc && has_result && (kind_next == KIND_ERROR || kind_next == KIND_END)
        |=> stopped_reg)
        else $error("parser not stopped after error or end");

    // data phase always has at least one byte to go
    a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> left_reg != 8'd0)
        else $error("data phase with no bytes left");

endmodule
